// ===== hw/rtl/mcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared types, codes and fixed-point constants of the motor command frame
// encoder: field limits, scale reciprocals and the rounding helpers.
// ----------------------------------------------------------------------------
package mcfe_pkg;

    // request codes of the input item
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_ENABLE  = 2'd1,
        FUNC_DISABLE = 2'd2,
        FUNC_ZERO    = 2'd3
    } func_t;

    // control mode codes (code 3 is unused and zeroes every field)
    localparam logic [1:0] MODE_POSITION = 2'd0;
    localparam logic [1:0] MODE_VELOCITY = 2'd1;
    localparam logic [1:0] MODE_TORQUE   = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_MODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_GAIN = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAMPING_GAIN  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID       = 8'd3;

    // register reset values
    localparam logic [1:0]  RESET_MODE    = MODE_POSITION;
    localparam logic [12:0] RESET_GAIN    = 13'd64;
    localparam logic [6:0]  RESET_NODE_ID = 7'd1;

    // fixed frames: seven 0xff bytes and a command byte
    localparam logic [55:0] FIXED_HEAD   = 56'hFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  TAIL_ENABLE  = 8'hFC;
    localparam logic [7:0]  TAIL_DISABLE = 8'hFD;
    localparam logic [7:0]  TAIL_ZERO    = 8'hFE;

    // field limits in the input fixed-point formats
    localparam int POS_LIM = 228764;
    localparam int VEL_LIM = 30720;
    localparam int KP_LIM  = 32000;
    localparam int KD_LIM  = 6400;
    localparam int TRQ_LIM = 24576;

    // code = floor((off * scale + span / 2) / span)
    localparam int POS_SPAN  = 2 * POS_LIM;
    localparam int VEL_SPAN  = 2 * VEL_LIM;
    localparam int KP_SPAN   = KP_LIM;
    localparam int KD_SPAN   = KD_LIM;
    localparam int TRQ_SPAN  = 2 * TRQ_LIM;
    localparam int POS_SCALE = 65535;
    localparam int SET_SCALE = 4095;

    // reciprocals scale * 2^32 / span, rounded down
    localparam int RECIP_SHIFT = 32;
    localparam logic [31:0] POS_RECIP =
        32'((64'(POS_SCALE) << RECIP_SHIFT) / 64'(POS_SPAN));
    localparam logic [31:0] VEL_RECIP =
        32'((64'(SET_SCALE) << RECIP_SHIFT) / 64'(VEL_SPAN));
    localparam logic [31:0] KP_RECIP =
        32'((64'(SET_SCALE) << RECIP_SHIFT) / 64'(KP_SPAN));
    localparam logic [31:0] KD_RECIP =
        32'((64'(SET_SCALE) << RECIP_SHIFT) / 64'(KD_SPAN));
    localparam logic [31:0] TRQ_RECIP =
        32'((64'(SET_SCALE) << RECIP_SHIFT) / 64'(TRQ_SPAN));
    localparam logic [51:0] EST_ROUND = 52'd1 << (RECIP_SHIFT - 1);

    // offsets after clamping, one item per stage
    typedef struct packed {
        logic        fixed;
        logic [7:0]  tail;
        logic [6:0]  frame_id;
        logic        drive_on;
        logic [18:0] pos_off;
        logic [15:0] vel_off;
        logic [12:0] kp_off;
        logic [12:0] kd_off;
        logic [15:0] trq_off;
    } front_item_t;

    // scaled numerators and code estimates
    typedef struct packed {
        logic        fixed;
        logic [7:0]  tail;
        logic [6:0]  frame_id;
        logic        drive_on;
        logic [34:0] pos_num;
        logic [27:0] vel_num;
        logic [25:0] kp_num;
        logic [24:0] kd_num;
        logic [27:0] trq_num;
        logic [15:0] pos_est;
        logic [11:0] vel_est;
        logic [11:0] kp_est;
        logic [11:0] kd_est;
        logic [11:0] trq_est;
    } scale_item_t;

    // final field codes
    typedef struct packed {
        logic [15:0] pos;
        logic [11:0] vel;
        logic [11:0] kp;
        logic [11:0] kd;
        logic [11:0] trq;
    } codes_t;

    // numerator off * scale + span / 2
    function automatic logic [34:0] scaled_num(logic [18:0] off, logic [15:0] scale,
                                               logic [17:0] half);
        return 35'(off) * 35'(scale) + 35'(half);
    endfunction

    // estimate of the rounded code, equal to the code or one below it
    function automatic logic [15:0] est_code(logic [18:0] off, logic [31:0] recip);
        logic [51:0] prod;
        prod = 52'(off) * 52'(recip) + EST_ROUND;
        return prod[RECIP_SHIFT+15:RECIP_SHIFT];
    endfunction

    // remainder check bumps the estimate where it fell one short
    function automatic logic [15:0] fix_code(logic [34:0] num, logic [15:0] est,
                                             logic [18:0] span);
        logic [34:0] rem;
        rem = num - 35'(est) * 35'(span);
        return (rem >= 35'(span)) ? est + 16'd1 : est;
    endfunction

endpackage

// ===== hw/rtl/motor_command_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_encoder
// Builds 8-byte actuator command frames from setpoint ticks and drive
// enable, disable and set-zero requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request item (func and the three targets). Enable,
//   disable and set-zero always give a fixed frame; a setpoint tick gives a
//   frame only while the drive is enabled, otherwise it is dropped.
//   m_ channel: frame_id, 64-bit payload (byte 0 in bits 63..56) and the
//   drive flag after the item.
//   cfg_ channel: register writes by index (0 mode, 1 kp, 2 kd, 3 node id),
//   always ready; write only while no item is in flight.
//   Path: an accepted item passes the input stage, the scale stage and the
//   output register in turn.
//   Throughput: one item per cycle while m_ready does not stall the output,
//   set by the three-stage pipeline that moves as a whole.
//   Reset: drive off, mode position, gains 64, node id 1, pipeline empty.
//   Stall: while the output register holds an untaken frame and m_ready is
//   low, the whole pipeline holds and s_ready is low.
// ----------------------------------------------------------------------------
module motor_command_frame_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mcfe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_func,
    input  logic signed [18:0]                s_position_target,
    input  logic signed [16:0]                s_velocity_target,
    input  logic signed [15:0]                s_torque_target,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [6:0]                        m_frame_id,
    output logic [63:0]                       m_frame_payload,
    output logic                              m_drive_on
);

    logic                  advance;
    logic                  a_valid;
    mcfe_pkg::front_item_t a_item;
    logic                  b_valid;
    mcfe_pkg::scale_item_t b_item;
    mcfe_pkg::codes_t      codes;

    logic        m_valid_reg;
    logic [6:0]  m_frame_id_reg;
    logic [63:0] m_frame_payload_reg;
    logic [63:0] m_frame_payload_next;
    logic        m_drive_on_reg;

    // the pipeline moves whenever the output register can take a frame
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    mcfe_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .advance           (advance),
        .s_valid           (s_valid),
        .s_func            (s_func),
        .s_position_target (s_position_target),
        .s_velocity_target (s_velocity_target),
        .s_torque_target   (s_torque_target),
        .a_valid           (a_valid),
        .a_item            (a_item)
    );

    mcfe_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .a_valid (a_valid),
        .a_item  (a_item),
        .b_valid (b_valid),
        .b_item  (b_item),
        .codes   (codes)
    );

    // payload packing
    assign m_frame_payload_next = b_item.fixed ? {mcfe_pkg::FIXED_HEAD, b_item.tail}
                                               : {codes.pos, codes.vel, codes.kp,
                                                  codes.kd, codes.trq};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_frame_id_reg      <= b_item.frame_id;
            m_frame_payload_reg <= m_frame_payload_next;
            m_drive_on_reg      <= b_item.drive_on;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_id      = m_frame_id_reg;
    assign m_frame_payload = m_frame_payload_reg;
    assign m_drive_on      = m_drive_on_reg;

    // checks

    // an accepted enable enters the pipeline as a fixed frame with the drive on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func == mcfe_pkg::FUNC_ENABLE)
        |=> (a_valid && a_item.fixed && a_item.drive_on))
        else $error("enable item lost or flag not set");

    // with the drive off only a disable or set-zero frame can leave
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_drive_on)
        |-> (m_frame_payload[63:8] == mcfe_pkg::FIXED_HEAD
             && (m_frame_payload[7:0] == mcfe_pkg::TAIL_DISABLE
                 || m_frame_payload[7:0] == mcfe_pkg::TAIL_ZERO)))
        else $error("setpoint frame emitted with drive off");

    // node id zero is saturated to one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_id != 7'd0))
        else $error("frame id zero emitted");

endmodule

// ===== hw/rtl/mcfe_front.sv =====
// ----------------------------------------------------------------------------
// mcfe_front
// Configuration registers, drive-enabled flag, field selection by control
// mode and clamping of each field to an offset from its lower limit.
// ----------------------------------------------------------------------------
module mcfe_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mcfe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              advance,
    input  logic                              s_valid,
    input  logic [1:0]                        s_func,
    input  logic signed [18:0]                s_position_target,
    input  logic signed [16:0]                s_velocity_target,
    input  logic signed [15:0]                s_torque_target,
    output logic                              a_valid,
    output mcfe_pkg::front_item_t             a_item
);

    logic [1:0]  control_mode_reg;
    logic [12:0] position_gain_reg;
    logic [12:0] damping_gain_reg;
    logic [6:0]  node_id_reg;
    logic        drive_enabled_reg;
    logic        drive_enabled_next;
    logic        a_valid_reg;
    logic        a_valid_next;
    mcfe_pkg::front_item_t a_item_reg;
    mcfe_pkg::front_item_t a_item_next;

    mcfe_pkg::func_t    func;
    logic               accept;
    logic signed [18:0] pos_x;
    logic signed [16:0] vel_x;
    logic signed [15:0] trq_x;
    logic [12:0]        kp_x;
    logic [12:0]        kd_x;
    logic signed [19:0] pos_sum;
    logic signed [17:0] vel_sum;
    logic signed [16:0] trq_sum;

    assign cfg_ready = 1'b1;
    assign func      = mcfe_pkg::func_t'(s_func);
    assign accept    = s_valid && advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_mode_reg  <= mcfe_pkg::RESET_MODE;
            position_gain_reg <= mcfe_pkg::RESET_GAIN;
            damping_gain_reg  <= mcfe_pkg::RESET_GAIN;
            node_id_reg       <= mcfe_pkg::RESET_NODE_ID;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mcfe_pkg::CFG_CONTROL_MODE:  control_mode_reg  <= cfg_data[1:0];
                mcfe_pkg::CFG_POSITION_GAIN: position_gain_reg <= cfg_data[12:0];
                mcfe_pkg::CFG_DAMPING_GAIN:  damping_gain_reg  <= cfg_data[12:0];
                mcfe_pkg::CFG_NODE_ID:       node_id_reg       <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // fields used by the control mode, the rest taken as zero
    always_comb begin
        pos_x = '0;
        vel_x = '0;
        trq_x = '0;
        kp_x  = '0;
        kd_x  = '0;
        if (control_mode_reg == mcfe_pkg::MODE_POSITION) begin
            pos_x = s_position_target;
            kp_x  = position_gain_reg;
            kd_x  = damping_gain_reg;
        end else if (control_mode_reg == mcfe_pkg::MODE_VELOCITY) begin
            vel_x = s_velocity_target;
            kd_x  = damping_gain_reg;
        end else if (control_mode_reg == mcfe_pkg::MODE_TORQUE) begin
            trq_x = s_torque_target;
        end
    end

    // offsets from the lower limits
    assign pos_sum = 20'(pos_x) + 20'(mcfe_pkg::POS_LIM);
    assign vel_sum = 18'(vel_x) + 18'(mcfe_pkg::VEL_LIM);
    assign trq_sum = 17'(trq_x) + 17'(mcfe_pkg::TRQ_LIM);

    // flag update, frame kind and clamped offsets
    always_comb begin
        drive_enabled_next = drive_enabled_reg;
        a_item_next        = a_item_reg;
        a_valid_next       = 1'b0;

        a_item_next.frame_id = (node_id_reg == 7'd0) ? 7'd1 : node_id_reg;
        a_item_next.fixed    = 1'b1;
        a_item_next.tail     = mcfe_pkg::TAIL_ZERO;

        unique case (func)
            mcfe_pkg::FUNC_TICK: begin
                a_item_next.fixed = 1'b0;
                a_valid_next      = drive_enabled_reg;
            end
            mcfe_pkg::FUNC_ENABLE: begin
                drive_enabled_next = 1'b1;
                a_item_next.tail   = mcfe_pkg::TAIL_ENABLE;
                a_valid_next       = 1'b1;
            end
            mcfe_pkg::FUNC_DISABLE: begin
                drive_enabled_next = 1'b0;
                a_item_next.tail   = mcfe_pkg::TAIL_DISABLE;
                a_valid_next       = 1'b1;
            end
            mcfe_pkg::FUNC_ZERO: begin
                a_valid_next = 1'b1;
            end
            default: ;
        endcase
        a_item_next.drive_on = drive_enabled_next;

        if (pos_sum < 20'sd0) begin
            a_item_next.pos_off = '0;
        end else if (pos_sum > 20'(mcfe_pkg::POS_SPAN)) begin
            a_item_next.pos_off = 19'(mcfe_pkg::POS_SPAN);
        end else begin
            a_item_next.pos_off = pos_sum[18:0];
        end

        if (vel_sum < 18'sd0) begin
            a_item_next.vel_off = '0;
        end else if (vel_sum > 18'(mcfe_pkg::VEL_SPAN)) begin
            a_item_next.vel_off = 16'(mcfe_pkg::VEL_SPAN);
        end else begin
            a_item_next.vel_off = vel_sum[15:0];
        end

        if (trq_sum < 17'sd0) begin
            a_item_next.trq_off = '0;
        end else if (trq_sum > 17'(mcfe_pkg::TRQ_SPAN)) begin
            a_item_next.trq_off = 16'(mcfe_pkg::TRQ_SPAN);
        end else begin
            a_item_next.trq_off = trq_sum[15:0];
        end

        // a 13-bit kp never reaches its limit
        a_item_next.kp_off = kp_x;
        a_item_next.kd_off = (kd_x > 13'(mcfe_pkg::KD_LIM)) ? 13'(mcfe_pkg::KD_LIM) : kd_x;

        if (!accept) begin
            drive_enabled_next = drive_enabled_reg;
            a_valid_next       = 1'b0;
        end
    end

    // flag and input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_enabled_reg <= 1'b0;
            a_valid_reg       <= 1'b0;
        end else begin
            drive_enabled_reg <= drive_enabled_next;
            if (advance) begin
                a_valid_reg <= a_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_item_reg <= a_item_next;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_item  = a_item_reg;

endmodule

// ===== hw/rtl/mcfe_scale.sv =====
// ----------------------------------------------------------------------------
// mcfe_scale
// Scales the clamped offsets to protocol codes with round-half-up: a
// reciprocal estimate and the numerator are registered, then a remainder
// check corrects the estimate.
// ----------------------------------------------------------------------------
module mcfe_scale (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   a_valid,
    input  mcfe_pkg::front_item_t  a_item,
    output logic                   b_valid,
    output mcfe_pkg::scale_item_t  b_item,
    output mcfe_pkg::codes_t       codes
);

    logic                  b_valid_reg;
    mcfe_pkg::scale_item_t b_item_reg;
    mcfe_pkg::scale_item_t b_item_next;

    // numerators and estimates from the offsets
    always_comb begin
        b_item_next.fixed    = a_item.fixed;
        b_item_next.tail     = a_item.tail;
        b_item_next.frame_id = a_item.frame_id;
        b_item_next.drive_on = a_item.drive_on;

        b_item_next.pos_num = mcfe_pkg::scaled_num(a_item.pos_off,
            16'(mcfe_pkg::POS_SCALE), 18'(mcfe_pkg::POS_LIM));
        b_item_next.vel_num = 28'(mcfe_pkg::scaled_num(19'(a_item.vel_off),
            16'(mcfe_pkg::SET_SCALE), 18'(mcfe_pkg::VEL_LIM)));
        b_item_next.kp_num  = 26'(mcfe_pkg::scaled_num(19'(a_item.kp_off),
            16'(mcfe_pkg::SET_SCALE), 18'(mcfe_pkg::KP_SPAN / 2)));
        b_item_next.kd_num  = 25'(mcfe_pkg::scaled_num(19'(a_item.kd_off),
            16'(mcfe_pkg::SET_SCALE), 18'(mcfe_pkg::KD_SPAN / 2)));
        b_item_next.trq_num = 28'(mcfe_pkg::scaled_num(19'(a_item.trq_off),
            16'(mcfe_pkg::SET_SCALE), 18'(mcfe_pkg::TRQ_LIM)));

        b_item_next.pos_est = mcfe_pkg::est_code(a_item.pos_off, mcfe_pkg::POS_RECIP);
        b_item_next.vel_est = 12'(mcfe_pkg::est_code(19'(a_item.vel_off),
            mcfe_pkg::VEL_RECIP));
        b_item_next.kp_est  = 12'(mcfe_pkg::est_code(19'(a_item.kp_off),
            mcfe_pkg::KP_RECIP));
        b_item_next.kd_est  = 12'(mcfe_pkg::est_code(19'(a_item.kd_off),
            mcfe_pkg::KD_RECIP));
        b_item_next.trq_est = 12'(mcfe_pkg::est_code(19'(a_item.trq_off),
            mcfe_pkg::TRQ_RECIP));
    end

    // scale stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_item_reg <= b_item_next;
        end
    end

    // remainder correction
    always_comb begin
        codes.pos = mcfe_pkg::fix_code(b_item_reg.pos_num, b_item_reg.pos_est,
            19'(mcfe_pkg::POS_SPAN));
        codes.vel = 12'(mcfe_pkg::fix_code(35'(b_item_reg.vel_num),
            16'(b_item_reg.vel_est), 19'(mcfe_pkg::VEL_SPAN)));
        codes.kp  = 12'(mcfe_pkg::fix_code(35'(b_item_reg.kp_num),
            16'(b_item_reg.kp_est), 19'(mcfe_pkg::KP_SPAN)));
        codes.kd  = 12'(mcfe_pkg::fix_code(35'(b_item_reg.kd_num),
            16'(b_item_reg.kd_est), 19'(mcfe_pkg::KD_SPAN)));
        codes.trq = 12'(mcfe_pkg::fix_code(35'(b_item_reg.trq_num),
            16'(b_item_reg.trq_est), 19'(mcfe_pkg::TRQ_SPAN)));
    end

    assign b_valid = b_valid_reg;
    assign b_item  = b_item_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor command frame encoder. A bench-side
// model tracks the drive flag and the four registers, predicts each frame at
// request acceptance and compares every emitted frame field by field. The
// run covers directed corners in each control mode, then random request
// streams under several idle and stall patterns with register changes
// between them.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 210;

    // mode code left unused by the protocol
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // register index that maps to nothing
    localparam logic [mcfe_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 8'd200;

    // extremes of the input fields
    localparam logic signed [18:0] POS_FLOOR = 19'(-262144);
    localparam logic signed [18:0] POS_CEIL  = 19'(262143);
    localparam logic signed [16:0] VEL_FLOOR = 17'(-65536);
    localparam logic signed [16:0] VEL_CEIL  = 17'(65535);
    localparam logic signed [15:0] TRQ_FLOOR = 16'(-32768);
    localparam logic signed [15:0] TRQ_CEIL  = 16'(32767);

    typedef struct packed {
        logic [6:0]  frame_id;
        logic [63:0] payload;
        logic        drive_on;
    } frame_t;

    logic                                  aclk              = 1'b0;
    logic                                  aresetn           = 1'b0;
    logic                                  cfg_valid         = 1'b0;
    logic                                  cfg_ready;
    logic [mcfe_pkg::CFG_INDEX_W-1:0]      cfg_index         = '0;
    logic [mcfe_pkg::CFG_DATA_W-1:0]       cfg_data          = '0;
    logic                                  s_valid           = 1'b0;
    logic                                  s_ready;
    logic [1:0]                            s_func            = '0;
    logic signed [18:0]                    s_position_target = '0;
    logic signed [16:0]                    s_velocity_target = '0;
    logic signed [15:0]                    s_torque_target   = '0;
    logic                                  m_valid;
    logic                                  m_ready           = 1'b0;
    logic [6:0]                            m_frame_id;
    logic [63:0]                           m_frame_payload;
    logic                                  m_drive_on;

    // bench copy of the block state and registers
    logic [1:0]  mode_reg   = mcfe_pkg::RESET_MODE;
    logic [12:0] kp_reg     = mcfe_pkg::RESET_GAIN;
    logic [12:0] kd_reg     = mcfe_pkg::RESET_GAIN;
    logic [6:0]  node_reg   = mcfe_pkg::RESET_NODE_ID;
    logic        drive_flag = 1'b0;

    frame_t pending_frames[$];
    int     error_count    = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     quiet_cycles   = 0;

    motor_command_frame_encoder DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_position_target (s_position_target),
        .s_velocity_target (s_velocity_target),
        .s_torque_target   (s_torque_target),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_id        (m_frame_id),
        .m_frame_payload   (m_frame_payload),
        .m_drive_on        (m_drive_on)
    );

    // clock
    always #5 aclk = ~aclk;

    // clamp to [lo, hi] and scale to 2^nbits - 1 steps, round half up
    function automatic longint field_code(longint x, longint lo, longint hi, int nbits);
        longint steps;
        longint span;
        longint off;
        steps = (longint'(1) << nbits) - 1;
        span  = hi - lo;
        if (x < lo) x = lo;
        else if (x > hi) x = hi;
        off = x - lo;
        return (2 * off * steps + span) / (2 * span);
    endfunction

    // frame for one request; updates the drive flag, returns 0 when dropped
    function automatic bit predict_frame(mcfe_pkg::func_t fn, longint pos_in, longint vel_in,
                                         longint trq_in, output frame_t fr);
        longint      p;
        longint      v;
        longint      kp;
        longint      kd;
        longint      t;
        logic [15:0] cp;
        logic [11:0] cv;
        logic [11:0] ckp;
        logic [11:0] ckd;
        logic [11:0] ct;
        p  = 0;
        v  = 0;
        kp = 0;
        kd = 0;
        t  = 0;
        fr.frame_id = (node_reg == 7'd0) ? 7'd1 : node_reg;
        fr.payload  = '0;
        case (fn)
            mcfe_pkg::FUNC_TICK: begin
                if (!drive_flag)
                    return 1'b0;
                case (mode_reg)
                    mcfe_pkg::MODE_POSITION: begin
                        p  = pos_in;
                        kp = longint'(kp_reg);
                        kd = longint'(kd_reg);
                    end
                    mcfe_pkg::MODE_VELOCITY: begin
                        v  = vel_in;
                        kd = longint'(kd_reg);
                    end
                    mcfe_pkg::MODE_TORQUE: begin
                        t = trq_in;
                    end
                    default: ;
                endcase
                cp  = 16'(field_code(p, -longint'(mcfe_pkg::POS_LIM),
                                     longint'(mcfe_pkg::POS_LIM), 16));
                cv  = 12'(field_code(v, -longint'(mcfe_pkg::VEL_LIM),
                                     longint'(mcfe_pkg::VEL_LIM), 12));
                ckp = 12'(field_code(kp, 0, longint'(mcfe_pkg::KP_LIM), 12));
                ckd = 12'(field_code(kd, 0, longint'(mcfe_pkg::KD_LIM), 12));
                ct  = 12'(field_code(t, -longint'(mcfe_pkg::TRQ_LIM),
                                     longint'(mcfe_pkg::TRQ_LIM), 12));
                fr.payload = {cp, cv, ckp, ckd, ct};
            end
            mcfe_pkg::FUNC_ENABLE: begin
                drive_flag = 1'b1;
                fr.payload = {mcfe_pkg::FIXED_HEAD, mcfe_pkg::TAIL_ENABLE};
            end
            mcfe_pkg::FUNC_DISABLE: begin
                drive_flag = 1'b0;
                fr.payload = {mcfe_pkg::FIXED_HEAD, mcfe_pkg::TAIL_DISABLE};
            end
            default: begin
                fr.payload = {mcfe_pkg::FIXED_HEAD, mcfe_pkg::TAIL_ZERO};
            end
        endcase
        fr.drive_on = drive_flag;
        return 1'b1;
    endfunction

    // random target: full field range, inside the limits, around a limit, extremes
    function automatic longint pick_target(longint lim, int width);
        longint full;
        full = longint'(1) << (width - 1);
        case ($urandom_range(3))
            0: return longint'($urandom_range(32'(2 * full - 1))) - full;
            1: return longint'($urandom_range(32'(2 * lim))) - lim;
            2: return ($urandom_range(1) ? lim : -lim) + longint'($urandom_range(6)) - 3;
            default: return $urandom_range(1) ? full - 1 : -full;
        endcase
    endfunction

    // mostly ticks, with enough enables to keep the drive on most of the time
    function automatic mcfe_pkg::func_t pick_func();
        int roll;
        roll = $urandom_range(99);
        if (roll < 68) return mcfe_pkg::FUNC_TICK;
        if (roll < 82) return mcfe_pkg::FUNC_ENABLE;
        if (roll < 90) return mcfe_pkg::FUNC_DISABLE;
        return mcfe_pkg::FUNC_ZERO;
    endfunction

    // send one request item, with a random gap before it
    task automatic send_request(mcfe_pkg::func_t fn, logic signed [18:0] pos,
                                logic signed [16:0] vel, logic signed [15:0] trq);
        frame_t fr;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid           <= 1'b1;
        s_func            <= fn;
        s_position_target <= pos;
        s_velocity_target <= vel;
        s_torque_target   <= trq;
        do @(posedge aclk); while (!s_ready);
        if (predict_frame(fn, longint'(pos), longint'(vel), longint'(trq), fr))
            pending_frames.push_back(fr);
    endtask

    // register write; the bench copy follows at acceptance
    task automatic write_reg(logic [mcfe_pkg::CFG_INDEX_W-1:0] idx,
                             logic [mcfe_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            mcfe_pkg::CFG_CONTROL_MODE:  mode_reg = data[1:0];
            mcfe_pkg::CFG_POSITION_GAIN: kp_reg   = data;
            mcfe_pkg::CFG_DAMPING_GAIN:  kd_reg   = data;
            mcfe_pkg::CFG_NODE_ID:       node_reg = data[6:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold requests until every frame is out and dropped ticks have left the pipe
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // reset values, drive off drops, fixed frames, position extremes
    task automatic test_reset_state();
        send_request(mcfe_pkg::FUNC_TICK, POS_CEIL, VEL_CEIL, TRQ_CEIL);
        send_request(mcfe_pkg::FUNC_ZERO, '0, '0, '0);
        send_request(mcfe_pkg::FUNC_DISABLE, '0, '0, '0);
        send_request(mcfe_pkg::FUNC_TICK, '0, '0, '0);
        send_request(mcfe_pkg::FUNC_ENABLE, '0, '0, '0);
        send_request(mcfe_pkg::FUNC_TICK, POS_FLOOR, VEL_FLOOR, TRQ_FLOOR);
        send_request(mcfe_pkg::FUNC_TICK, POS_CEIL, VEL_CEIL, TRQ_CEIL);
        send_request(mcfe_pkg::FUNC_TICK, 19'(-mcfe_pkg::POS_LIM), '0, '0);
        send_request(mcfe_pkg::FUNC_TICK, 19'(mcfe_pkg::POS_LIM), '0, '0);
        send_request(mcfe_pkg::FUNC_TICK, '0, '0, '0);
        send_request(mcfe_pkg::FUNC_TICK, -19'sd1, '0, '0);
        send_request(mcfe_pkg::FUNC_ZERO, 19'sd1, 17'sd1, 16'sd1);
    endtask

    // each control mode with gain and node id extremes
    task automatic test_control_modes();
        wait_idle();
        write_reg(mcfe_pkg::CFG_POSITION_GAIN, 13'd8191);
        write_reg(mcfe_pkg::CFG_DAMPING_GAIN, 13'd8191);
        write_reg(mcfe_pkg::CFG_NODE_ID, 13'd0);
        send_request(mcfe_pkg::FUNC_TICK, 19'sd1, VEL_CEIL, TRQ_CEIL);
        wait_idle();
        write_reg(mcfe_pkg::CFG_CONTROL_MODE, {11'd0, mcfe_pkg::MODE_VELOCITY});
        write_reg(mcfe_pkg::CFG_DAMPING_GAIN, 13'(mcfe_pkg::KD_LIM));
        write_reg(mcfe_pkg::CFG_NODE_ID, 13'd127);
        send_request(mcfe_pkg::FUNC_TICK, POS_CEIL, VEL_FLOOR, TRQ_CEIL);
        send_request(mcfe_pkg::FUNC_TICK, POS_FLOOR, VEL_CEIL, TRQ_FLOOR);
        send_request(mcfe_pkg::FUNC_TICK, '0, 17'(mcfe_pkg::VEL_LIM), '0);
        wait_idle();
        write_reg(mcfe_pkg::CFG_CONTROL_MODE, {11'd0, mcfe_pkg::MODE_TORQUE});
        send_request(mcfe_pkg::FUNC_TICK, POS_CEIL, VEL_CEIL, TRQ_FLOOR);
        send_request(mcfe_pkg::FUNC_TICK, '0, '0, TRQ_CEIL);
        send_request(mcfe_pkg::FUNC_TICK, '0, '0, 16'(-mcfe_pkg::TRQ_LIM));
        wait_idle();
        write_reg(mcfe_pkg::CFG_CONTROL_MODE, {11'd0, MODE_UNUSED});
        write_reg(CFG_UNUSED, 13'h1FFF);
        send_request(mcfe_pkg::FUNC_TICK, POS_CEIL, VEL_CEIL, TRQ_CEIL);
        wait_idle();
        write_reg(mcfe_pkg::CFG_CONTROL_MODE, {11'd0, mcfe_pkg::MODE_POSITION});
        write_reg(mcfe_pkg::CFG_POSITION_GAIN, 13'd0);
        write_reg(mcfe_pkg::CFG_DAMPING_GAIN, 13'd0);
        send_request(mcfe_pkg::FUNC_TICK, 19'(mcfe_pkg::POS_LIM), '0, '0);
        send_request(mcfe_pkg::FUNC_DISABLE, '0, '0, '0);
        send_request(mcfe_pkg::FUNC_TICK, 19'(mcfe_pkg::POS_LIM), '0, '0);
    endtask

    // new random register values, upper data bits left random
    task automatic shuffle_registers();
        logic [12:0] kp;
        logic [12:0] kd;
        case ($urandom_range(3))
            0: kp = 13'd0;
            1: kp = 13'd8191;
            default: kp = 13'($urandom_range(8191));
        endcase
        case ($urandom_range(4))
            0: kd = 13'd0;
            1: kd = 13'(mcfe_pkg::KD_LIM);
            2: kd = 13'd8191;
            default: kd = 13'($urandom_range(8191));
        endcase
        write_reg(mcfe_pkg::CFG_CONTROL_MODE, {11'($urandom), 2'($urandom_range(3))});
        write_reg(mcfe_pkg::CFG_POSITION_GAIN, kp);
        write_reg(mcfe_pkg::CFG_DAMPING_GAIN, kd);
        write_reg(mcfe_pkg::CFG_NODE_ID, {6'($urandom), 7'($urandom_range(127))});
    endtask

    // random requests under each idle pattern, registers changed between phases
    task automatic test_random_traffic();
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 54, 0, 7};
        recv_pct = '{0, 0, 54, 7};
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            shuffle_registers();
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            send_request(mcfe_pkg::FUNC_ENABLE, '0, '0, '0);
            repeat (PHASE_ITEMS) begin
                send_request(pick_func(),
                             19'(pick_target(longint'(mcfe_pkg::POS_LIM), 19)),
                             17'(pick_target(longint'(mcfe_pkg::VEL_LIM), 17)),
                             16'(pick_target(longint'(mcfe_pkg::TRQ_LIM), 16)));
            end
        end
    endtask

    // frame check and receiver stall
    always @(posedge aclk) begin : check_frames
        frame_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                error_count++;
                $display("%0t unexpected frame: expected none actual id %0d payload %h",
                         $time, m_frame_id, m_frame_payload);
            end else begin
                want = pending_frames.pop_front();
                if (m_frame_id !== want.frame_id) begin
                    error_count++;
                    $display("%0t frame_id mismatch: expected %0d actual %0d",
                             $time, want.frame_id, m_frame_id);
                end
                if (m_frame_payload !== want.payload) begin
                    error_count++;
                    $display("%0t frame_payload mismatch: expected %h actual %h",
                             $time, want.payload, m_frame_payload);
                end
                if (m_drive_on !== want.drive_on) begin
                    error_count++;
                    $display("%0t drive_on mismatch: expected %0b actual %0b",
                             $time, want.drive_on, m_drive_on);
                end
            end
        end
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t timeout: %0d frames still expected", $time, pending_frames.size());
            $display("** motor_command_frame_encoder: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_control_modes();
        test_random_traffic();
        wait_idle();
        if (error_count == 0) begin
            $display("** motor_command_frame_encoder: PASSED **");
        end else begin
            $display("** motor_command_frame_encoder: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mcfe_pkg.sv
hw/rtl/mcfe_front.sv
hw/rtl/mcfe_scale.sv
hw/rtl/motor_command_frame_encoder.sv
tb/sv/testbench.sv
